### rtl/core/multi_key_auto_repeat_defines.svh
// Assertion macros shared by the multi-key auto-repeat RTL.
`ifndef MULTI_KEY_AUTO_REPEAT_DEFINES_SVH
`define MULTI_KEY_AUTO_REPEAT_DEFINES_SVH
`ifndef SYNTH
// Checked property, disabled while reset is high.
`define MKAR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that is also evaluated during reset.
`define MKAR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MKAR_ASSERT(label, clk, rst, prop, msg)
`define MKAR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/core/mkar_pkg.sv
// Types and constants of the multi-key auto-repeat block.
package mkar_pkg;

   localparam int CNT_W     = 10;
   localparam int HELD_W    = 4;
   localparam int DIR_W     = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [CNT_W-1:0] CNT_MAX        = '1;
   localparam logic [CNT_W-1:0] DELAY_RESET    = 10'd20;
   localparam logic [CNT_W-1:0] INTERVAL_RESET = 10'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_DELAY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_INTERVAL = 2'd1;

   typedef struct packed {
      logic [CNT_W-1:0] initial_delay;
      logic [CNT_W-1:0] repeat_interval;
   } cfg_type;

endpackage

### rtl/core/mkar_dir_cell.sv
// Per-direction hold counter and repeat state for one direction button.
`include "multi_key_auto_repeat_defines.svh"

module mkar_dir_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              held,
   input  mkar_pkg::cfg_type cfg,
   output logic              fire
);

   logic [mkar_pkg::CNT_W-1:0] frame_count_ff, frame_count_in;
   logic                       was_pressed_ff, was_pressed_in;
   logic                       repeating_ff, repeating_in;
   logic [mkar_pkg::CNT_W-1:0] bumped;

   assign bumped = (frame_count_ff == mkar_pkg::CNT_MAX) ? mkar_pkg::CNT_MAX
                                                         : frame_count_ff + 1'b1;

   always_comb begin
      frame_count_in = frame_count_ff;
      was_pressed_in = was_pressed_ff;
      repeating_in   = repeating_ff;
      fire           = 1'b0;
      if (!held) begin
         frame_count_in = '0;
         was_pressed_in = 1'b0;
         repeating_in   = 1'b0;
      end else if (!was_pressed_ff) begin
         // First held frame: count is one, or fires if delay <= 1.
         was_pressed_in = 1'b1;
         if (cfg.initial_delay <= mkar_pkg::CNT_W'(1)) begin
            fire           = 1'b1;
            repeating_in   = 1'b1;
            frame_count_in = '0;
         end else begin
            repeating_in   = 1'b0;
            frame_count_in = mkar_pkg::CNT_W'(1);
         end
      end else if (!repeating_ff) begin
         if (bumped >= cfg.initial_delay) begin
            fire           = 1'b1;
            repeating_in   = 1'b1;
            frame_count_in = '0;
         end else begin
            frame_count_in = bumped;
         end
      end else begin
         if (bumped >= cfg.repeat_interval) begin
            fire           = 1'b1;
            frame_count_in = '0;
         end else begin
            frame_count_in = bumped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         was_pressed_ff <= 1'b0;
         repeating_ff   <= 1'b0;
      end else if (step) begin
         frame_count_ff <= frame_count_in;
         was_pressed_ff <= was_pressed_in;
         repeating_ff   <= repeating_in;
      end
   end

   `MKAR_ASSERT(a_repeat_needs_hold, clock, reset, repeating_ff |-> was_pressed_ff, "repeat without hold")
   `MKAR_ASSERT(a_idle_count_zero, clock, reset, !was_pressed_ff |-> (frame_count_ff == '0), "count kept after release")
   `MKAR_ASSERT(a_release_clears, clock, reset, (step && !held) |=> !was_pressed_ff && !repeating_ff, "release did not clear")

endmodule

### rtl/core/mkar_prio_enc.sv
// Lowest-index pick among the directions that fired this frame.
module mkar_prio_enc #(
   parameter int NUM_DIRECTIONS = 4
) (
   input  logic [NUM_DIRECTIONS-1:0]  fire_vec,
   output logic                       any_fire,
   output logic [mkar_pkg::DIR_W-1:0] first_dir
);

   always_comb begin
      first_dir = '0;
      for (int i = NUM_DIRECTIONS - 1; i >= 0; i--) begin
         if (fire_vec[i]) begin
            first_dir = mkar_pkg::DIR_W'(i);
         end
      end
   end

   assign any_fire = |fire_vec;

endmodule

### rtl/core/multi_key_auto_repeat.sv
// Top level of the multi-key auto-repeat block.
// Each request beat is one frame tick with the mask of held direction buttons; each
// accepted beat yields exactly one response beat that flags whether any direction fired
// and names the lowest one that did. A beat is registered at the input, then all
// direction counters update as the response register is loaded; a response is
// offered from the response register, and a stalled response holds the beat in the
// input register. One beat is taken every cycle as long as the response side keeps
// taking beats. Direction counters saturate at 1023. Configuration writes take
// effect on the next frame and belong to idle periods.
`include "multi_key_auto_repeat_defines.svh"

module multi_key_auto_repeat #(
   parameter int NUM_DIRECTIONS = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [mkar_pkg::HELD_W-1:0]    req_held_buttons,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_fire_valid,
   output logic [mkar_pkg::DIR_W-1:0]     rsp_fire_direction,
   input  logic                           csr_write_enable,
   input  logic [mkar_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mkar_pkg::CNT_W-1:0]     csr_write_data
);

   mkar_pkg::cfg_type cfg_ff;

   logic                        s1_valid_ff;
   logic [mkar_pkg::HELD_W-1:0] s1_held_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_fire_valid_ff, rsp_fire_valid_in;
   logic [mkar_pkg::DIR_W-1:0]  rsp_fire_direction_ff, rsp_fire_direction_in;
   logic                        advance;
   logic                        s1_ready;
   logic [NUM_DIRECTIONS-1:0]   fire_vec;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_delay   <= mkar_pkg::DELAY_RESET;
         cfg_ff.repeat_interval <= mkar_pkg::INTERVAL_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mkar_pkg::CSR_INITIAL_DELAY:   cfg_ff.initial_delay   <= csr_write_data;
            mkar_pkg::CSR_REPEAT_INTERVAL: cfg_ff.repeat_interval <= csr_write_data;
            default: ;
         endcase
      end
   end

   // The frame in the input register moves on whenever the response slot is free or its beat is being taken.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign s1_ready  = !s1_valid_ff || advance;
   assign req_stall = !s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_held_ff <= req_held_buttons;
      end
   end

   for (genvar d = 0; d < NUM_DIRECTIONS; d++) begin : g_dir
      logic held;
      // Directions beyond the width of the button mask are never held.
      if (d < mkar_pkg::HELD_W) begin : g_held
         assign held = s1_held_ff[d];
      end else begin : g_none
         assign held = 1'b0;
      end
      mkar_dir_cell u_cell (
         .clock (clock),
         .reset (reset),
         .step  (advance),
         .held  (held),
         .cfg   (cfg_ff),
         .fire  (fire_vec[d])
      );
   end

   mkar_prio_enc #(
      .NUM_DIRECTIONS (NUM_DIRECTIONS)
   ) u_prio (
      .fire_vec  (fire_vec),
      .any_fire  (rsp_fire_valid_in),
      .first_dir (rsp_fire_direction_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_fire_valid_ff     <= rsp_fire_valid_in;
         rsp_fire_direction_ff <= rsp_fire_direction_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_fire_valid     = rsp_fire_valid_ff;
   assign rsp_fire_direction = rsp_fire_direction_ff;

   `MKAR_ASSERT(a_no_fire_dir_zero, clock, reset, (rsp_valid_ff && !rsp_fire_valid_ff) |-> (rsp_fire_direction_ff == '0), "direction set without a firing")
   `MKAR_ASSERT(a_stall_needs_item, clock, reset, req_stall |-> (s1_valid_ff && rsp_valid_ff), "input stalled with room")
   `MKAR_ASSERT(a_advance_loads_rsp, clock, reset, advance |=> rsp_valid_ff, "advanced frame lost")
   `MKAR_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (!s1_valid_ff && !rsp_valid_ff), "pipeline not empty after reset")

endmodule
